### design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define U8_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define U8_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/u8u16_pkg.sv
// types and constants for the utf-8 to utf-16 transcoder
// no dependencies
package u8u16_pkg;

  localparam logic [7:0]  LEAD2_MIN  = 8'hC2;
  localparam logic [7:0]  LEAD3_MIN  = 8'hE0;
  localparam logic [7:0]  LEAD4_MIN  = 8'hF0;
  localparam logic [7:0]  LEAD_BAD   = 8'hF8;
  localparam logic [20:0] MAX_CP     = 21'h10FFFF;
  localparam logic [20:0] BMP_LIMIT  = 21'h010000;
  localparam logic [15:0] SURR_HI    = 16'hD800;
  localparam logic [15:0] SURR_LO    = 16'hDC00;

  localparam logic [1:0] CONT_TAG = 2'b10;

  typedef struct packed {
    logic [15:0] unit;
    logic        rep;
    logic        fail;
  } result_t;

  // all results caused by one byte, entry 0 first
  typedef struct packed {
    result_t [2:0] ent;
    logic [1:0]    cnt;
  } group_t;

endpackage

### design/utf8_to_utf16_transcoder.sv
// utf-8 to utf-16 transcoder, top level
// depends on u8u16_pkg, u8u16_decode, u8u16_outbuf
//
// Takes one byte of a utf-8 string per input transfer, in_last on the final
// byte, and gives utf-16 code units, one per output transfer: one unit for a
// code point below 0x10000, a surrogate pair above. After the final byte a
// report (is_report high, code_unit zero) says whether the string was valid;
// on failed the string's units must be discarded. Errors stop further units
// for the rest of the string. A byte is decoded in the cycle it is taken and
// its results (none to three) land in a result register, so bytes are taken
// every cycle as long as each causes at most one result and the output keeps
// up; a byte that causes more than one result holds the output until all have
// gone out, and the next byte is taken in the cycle its last result goes out.
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        is_report,
  output logic        failed,
  output logic        last_of_run
);
  import u8u16_pkg::*;

  group_t grp;
  logic   free;
  logic   load;

  assign in_ready = free;
  assign load     = in_valid && free;

  u8u16_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .in_byte (in_byte),
    .in_last (in_last),
    .grp     (grp)
  );

  u8u16_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .grp         (grp),
    .free        (free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_unit   (code_unit),
    .is_report   (is_report),
    .failed      (failed),
    .last_of_run (last_of_run)
  );

endmodule

### design/u8u16_decode.sv
// utf-8 decode state and per-byte result generation
// depends on u8u16_pkg
module u8u16_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output u8u16_pkg::group_t grp
);
  import u8u16_pkg::*;

  logic [1:0]  rem, rem_next;
  logic [2:0]  len, len_next;
  logic [20:0] acc, acc_next;
  logic        err, err_next;

  logic [20:0] acc_shift;
  logic        second;
  logic        cp_emit;
  logic [20:0] cp_val;
  logic [20:0] cp_off;
  logic [1:0]  n_units;
  logic [15:0] u0, u1;
  logic        fail;
  result_t     rpt;

  assign acc_shift = {acc[14:0], in_byte[5:0]};
  assign second    = (({1'b0, rem} + 3'd1) == len);
  assign cp_off    = cp_val - BMP_LIMIT;

  always_comb begin
    rem_next = rem;
    len_next = len;
    acc_next = acc;
    err_next = err;
    cp_emit  = 1'b0;
    cp_val   = acc_shift;
    if (!err) begin
      if (rem == 2'd0) begin
        if (!in_byte[7]) begin
          cp_emit = 1'b1;
          cp_val  = {13'd0, in_byte};
        end else if (in_byte >= LEAD2_MIN && in_byte < LEAD3_MIN) begin
          acc_next = {16'd0, in_byte[4:0]};
          len_next = 3'd2;
          rem_next = 2'd1;
        end else if (in_byte >= LEAD3_MIN && in_byte < LEAD4_MIN) begin
          acc_next = {17'd0, in_byte[3:0]};
          len_next = 3'd3;
          rem_next = 2'd2;
        end else if (in_byte >= LEAD4_MIN && in_byte < LEAD_BAD) begin
          acc_next = {18'd0, in_byte[2:0]};
          len_next = 3'd4;
          rem_next = 2'd3;
        end else begin
          err_next = 1'b1;
        end
      end else if (in_byte[7:6] != CONT_TAG) begin
        err_next = 1'b1;
      end else if (second && acc == '0 &&
                   ((len == 3'd3 && !in_byte[5]) ||
                    (len == 3'd4 && in_byte[5:4] == 2'b00))) begin
        // overlong three or four byte form
        err_next = 1'b1;
      end else begin
        acc_next = acc_shift;
        rem_next = rem - 2'd1;
        if (rem == 2'd1) begin
          cp_emit  = 1'b1;
          acc_next = '0;
          len_next = '0;
        end
      end
    end

    n_units = 2'd0;
    u0      = cp_val[15:0];
    u1      = '0;
    if (cp_emit) begin
      if (cp_val > MAX_CP) begin
        err_next = 1'b1;
      end else if (cp_val < BMP_LIMIT) begin
        n_units = 2'd1;
      end else begin
        n_units = 2'd2;
        u0      = SURR_HI | {6'd0, cp_off[19:10]};
        u1      = SURR_LO | {6'd0, cp_off[9:0]};
      end
    end

    // cut-off sequence fails the string
    fail = err_next | (rem_next != 2'd0);
    rpt  = '{unit: '0, rep: 1'b1, fail: fail};

    grp = '0;
    case (n_units)
      2'd1: begin
        grp.ent[0] = '{unit: u0, rep: 1'b0, fail: 1'b0};
        grp.ent[1] = rpt;
      end
      2'd2: begin
        grp.ent[0] = '{unit: u0, rep: 1'b0, fail: 1'b0};
        grp.ent[1] = '{unit: u1, rep: 1'b0, fail: 1'b0};
        grp.ent[2] = rpt;
      end
      default: begin
        grp.ent[0] = rpt;
      end
    endcase
    grp.cnt = n_units + {1'b0, in_last};

    if (in_last) begin
      rem_next = '0;
      len_next = '0;
      acc_next = '0;
      err_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      len <= '0;
      acc <= '0;
      err <= 1'b0;
    end else if (load) begin
      rem <= rem_next;
      len <= len_next;
      acc <= acc_next;
      err <= err_next;
    end
  end

endmodule

### design/u8u16_outbuf.sv
// result register holding the results of one byte, sent one per transfer
// depends on u8u16_pkg
module u8u16_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  u8u16_pkg::group_t grp,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       code_unit,
  output logic              is_report,
  output logic              failed,
  output logic              last_of_run
);
  import u8u16_pkg::*;

  result_t [2:0] ent;
  logic [1:0]    cnt;
  logic [1:0]    idx;
  logic          take;
  logic          at_last;
  result_t       cur;

  assign out_valid = (cnt != 2'd0);
  assign at_last   = (idx == cnt - 2'd1);
  assign take      = out_valid && out_ready;
  assign free      = !out_valid || (take && at_last);

  always_comb begin
    case (idx)
      2'd1:    cur = ent[1];
      2'd2:    cur = ent[2];
      default: cur = ent[0];
    endcase
  end

  assign code_unit   = cur.unit;
  assign is_report   = cur.rep;
  assign failed      = cur.fail;
  assign last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= grp.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= grp.cnt;
      idx <= '0;
    end else if (take) begin
      if (at_last) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

### design/u8u16_checker.sv
// port-level checks for the transcoder, bound to the top level
// depends on assert_macros.svh and utf8_to_utf16_transcoder
`include "assert_macros.svh"

module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] code_unit,
  input logic        is_report,
  input logic        failed,
  input logic        last_of_run
);

  // a stalled result holds
  `U8_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(is_report) && $stable(failed), "stalled result changed")

  // the report is always the final result of its byte
  `U8_ASSERT(a_report_last, clk, rst, out_valid && is_report |-> last_of_run && code_unit == 16'd0, "report not last or nonzero")

  // units never carry a failure flag
  `U8_ASSERT(a_unit_ok, clk, rst, out_valid && !is_report |-> !failed, "failed set on a unit")

  // no new byte while a byte still has results to send after this one
  `U8_ASSERT(a_no_overrun, clk, rst, out_valid && !last_of_run |-> !in_ready, "byte taken mid-run")

  // nothing is offered right after reset
  `U8_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .code_unit   (code_unit),
  .is_report   (is_report),
  .failed      (failed),
  .last_of_run (last_of_run)
);
